@@ src/msa_pkg.sv @@
package msa_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int CFG_W = 7;
	localparam int SLOT_W = 6;
	localparam int STAT_W = 2;

	localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(64);

	localparam logic OP_TAKE = 1'b0;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

@@ src/msa_core.sv @@
module msa_core import msa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  logic [SLOT_W-1:0] idx,
	input  logic [CNT_W-1:0]  row_len,
	input  logic              room,
	output core_stat_t        stat,
	output result_t           res
);

	state_t state_q, state_d;

	logic [MAX_SLOTS-1:0] map_q;
	logic [MAX_SLOTS-1:0] map_rot;
	logic [IDX_W-1:0]     pos_q;
	logic                 op_q;
	logic [SLOT_W-1:0]    idx_q;
	logic                 have_prev_q;
	logic [IDX_W-1:0]     prev_q;
	logic                 have_best_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [IDX_W-1:0]     best_dist_q;
	logic                 rel_ok_q;

	logic             cur_occ;
	logic             in_row;
	logic             last;
	logic [IDX_W-1:0] diff;
	logic             cand;
	logic [IDX_W-1:0] cand_slot;
	logic [IDX_W-1:0] cand_dist;
	logic             better;
	logic             clr;
	logic [CNT_W-1:0] row_last;
	logic             tail_cand;
	logic [IDX_W-1:0] tail_dist;
	logic             fin_ok;
	logic [IDX_W-1:0] fin_slot;
	logic             done;

	assign cur_occ = map_q[0];
	assign in_row  = {1'b0, pos_q} < row_len;
	assign last    = pos_q == IDX_W'(MAX_SLOTS - 1);
	assign diff    = pos_q - prev_q;
	assign clr     = (op_q != OP_TAKE) && in_row && (int'(pos_q) == int'(idx_q));

	// one slot per cycle: the slot under test sits in bit 0
	always_comb begin
		for (int k = 0; k < MAX_SLOTS; k++) begin
			if (k == MAX_SLOTS - 1) begin
				map_rot[k] = map_q[0] & ~clr;
			end else begin
				map_rot[k] = map_q[(k + 1) % MAX_SLOTS];
			end
		end
	end

	always_comb begin
		cand      = 1'b0;
		cand_slot = '0;
		cand_dist = '0;
		if ((op_q == OP_TAKE) && in_row && cur_occ) begin
			if (!have_prev_q) begin
				if (pos_q != '0) begin
					cand      = 1'b1;
					cand_slot = '0;
					cand_dist = pos_q;
				end
			end else if ({1'b0, diff} >= CNT_W'(2)) begin
				cand      = 1'b1;
				cand_dist = diff >> 1;
				cand_slot = prev_q + (diff >> 1);
			end
		end
		better = cand && (!have_best_q || (cand_dist > best_dist_q));
	end

	// right-hand wall
	assign row_last  = row_len - CNT_W'(1);
	assign tail_cand = have_prev_q && ({1'b0, prev_q} < row_last);
	assign tail_dist = IDX_W'(row_last - {1'b0, prev_q});

	always_comb begin
		fin_ok   = 1'b1;
		fin_slot = '0;
		if (!have_prev_q) begin
			fin_slot = '0;
		end else if (tail_cand && (!have_best_q || (tail_dist > best_dist_q))) begin
			fin_slot = IDX_W'(row_last);
		end else if (have_best_q) begin
			fin_slot = best_slot_q;
		end else begin
			fin_ok = 1'b0;
		end
	end

	always_comb begin
		res = '{chosen_slot: '0, status: ST_OK};
		if (op_q == OP_TAKE) begin
			if (fin_ok) begin
				res.chosen_slot = SLOT_W'(fin_slot);
			end else begin
				res.status = ST_FULL;
			end
		end else if (!rel_ok_q) begin
			res.status = ST_BAD_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (room) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign stat.idle = state_q == S_IDLE;
	assign stat.done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			pos_q       <= '0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			rel_ok_q    <= 1'b0;
		end else if ((state_q == S_IDLE) && start) begin
			pos_q       <= '0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			rel_ok_q    <= 1'b0;
		end else if (state_q == S_SCAN) begin
			map_q <= map_rot;
			pos_q <= pos_q + IDX_W'(1);
			if (in_row && cur_occ) begin
				have_prev_q <= 1'b1;
			end
			if (better) begin
				have_best_q <= 1'b1;
			end
			if (clr && cur_occ) begin
				rel_ok_q <= 1'b1;
			end
		end else if (done && (op_q == OP_TAKE) && fin_ok) begin
			map_q[fin_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			op_q  <= op;
			idx_q <= idx;
		end
		if (state_q == S_SCAN) begin
			if (in_row && cur_occ) begin
				prev_q <= pos_q;
			end
			if (better) begin
				best_slot_q <= cand_slot;
				best_dist_q <= cand_dist;
			end
		end
	end

endmodule

@@ src/max_distance_slot_allocator.sv @@
// Max-distance slot allocator. A take beat picks the free slot farthest from its nearest
// occupied neighbour (walls count as free, ties to the lowest slot, empty row gives slot 0),
// marks it and returns it; a release beat frees one occupied slot. Status 1 flags a take on
// a full row, status 2 a release of a free or out-of-range slot; neither changes the map.
// The occupancy map lives in a rotating shift register that is walked one slot per clock,
// and the block takes no new input beat during a walk: the next input beat is taken once
// the result has moved to the output register, where it may still wait, and a request
// that finishes its walk while a result still waits is held until that result is taken.
// slot_count may be written only while no request is in flight; 0 acts as 1 and values
// above MAX_SLOTS act as MAX_SLOTS. The map is all free after reset.
module max_distance_slot_allocator import msa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // opcode, slot_index
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata   // chosen_slot, status
);

	logic [CFG_W-1:0] slot_count_q;
	logic [CNT_W-1:0] row_len;
	logic             m_tvalid_q;
	result_t          out_q;
	result_t          res;
	core_stat_t       stat;
	logic             room;
	logic             start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (slot_count_q == '0) begin
			row_len = CNT_W'(1);
		end else if (int'(slot_count_q) > MAX_SLOTS) begin
			row_len = CNT_W'(MAX_SLOTS);
		end else begin
			row_len = CNT_W'(slot_count_q);
		end
	end

	assign room     = !m_tvalid_q || m_tready;
	assign s_tready = stat.idle;
	assign start    = s_tvalid && stat.idle;

	msa_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (s_tdata[0]),
		.idx     (s_tdata[SLOT_W:1]),
		.row_len (row_len),
		.room    (room),
		.stat    (stat),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.status, out_q.chosen_slot};

endmodule

@@ bench/msa_checker.sv @@
`timescale 1ns / 100ps

module msa_checker import msa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // opcode, slot_index
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,   // chosen_slot, status
	output int                   mismatches,
	output int                   pending,
	output logic [MAX_SLOTS-1:0] occupied
);

	logic [MAX_SLOTS-1:0] seat_map;
	logic [CFG_W-1:0]     slot_count;
	result_t              expected_q[$];
	int                   bad_count;

	function automatic int row_len(input logic [CFG_W-1:0] cnt);
		if (cnt == 0)
			return 1;
		if (cnt > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(cnt);
	endfunction

	// farthest free slot from any occupied one, walls count as free
	function automatic bit farthest_free_slot(input logic [MAX_SLOTS-1:0] map, input int n,
			output logic [SLOT_W-1:0] pick);
		bit seen_prev;
		bit have_best;
		bit cand;
		int prev;
		int best_at;
		int top_gap;
		int cand_at;
		int cand_gap;
		seen_prev = 0;
		have_best = 0;
		prev = 0;
		best_at = 0;
		top_gap = 0;
		pick = '0;
		for (int i = 0; i < n; i++) begin
			if (map[i]) begin
				cand = 0;
				cand_at = 0;
				cand_gap = 0;
				if (!seen_prev) begin
					if (i > 0) begin
						cand = 1;
						cand_gap = i;
					end
				end else if (i - prev >= 2) begin
					cand = 1;
					cand_gap = (i - prev) / 2;
					cand_at = prev + cand_gap;
				end
				if (cand && (!have_best || cand_gap > top_gap)) begin
					have_best = 1;
					best_at = cand_at;
					top_gap = cand_gap;
				end
				seen_prev = 1;
				prev = i;
			end
		end
		if (!seen_prev)
			return 1;
		if (prev < n - 1) begin
			cand_gap = n - 1 - prev;
			if (!have_best || cand_gap > top_gap) begin
				have_best = 1;
				best_at = n - 1;
			end
		end
		pick = SLOT_W'(best_at);
		return have_best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		logic [SLOT_W-1:0] got_slot;
		logic [STAT_W-1:0] got_stat;
		logic [SLOT_W-1:0] idx;
		logic [SLOT_W-1:0] pick;
		int n;
		if (!arst_n) begin
			seat_map = '0;
			slot_count = SLOT_COUNT_RST;
			expected_q.delete();
			bad_count = 0;
			mismatches <= 0;
			pending <= 0;
			occupied <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_slot = m_tdata[SLOT_W-1:0];
				got_stat = m_tdata[SLOT_W+STAT_W-1:SLOT_W];
				if (expected_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: result beat with none expected: slot %0d status %0d",
							$realtime, got_slot, got_stat);
				end else begin
					exp_r = expected_q.pop_front();
					if (got_slot !== exp_r.chosen_slot || got_stat !== exp_r.status) begin
						bad_count++;
						if (bad_count <= 10)
							$display("%0t: mismatch: slot exp %0d got %0d, status exp %0d got %0d",
								$realtime, exp_r.chosen_slot, got_slot, exp_r.status, got_stat);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n = row_len(slot_count);
				exp_r.chosen_slot = '0;
				exp_r.status = ST_OK;
				if (s_tdata[0] == OP_TAKE) begin
					if (farthest_free_slot(seat_map, n, pick)) begin
						seat_map[pick] = 1'b1;
						exp_r.chosen_slot = pick;
					end else begin
						exp_r.status = ST_FULL;
					end
				end else begin
					idx = s_tdata[SLOT_W:1];
					if (int'(idx) >= n || !seat_map[idx])
						exp_r.status = ST_BAD_RELEASE;
					else
						seat_map[idx] = 1'b0;
				end
				expected_q.push_back(exp_r);
			end
			if (cfg_we)
				slot_count = cfg_wdata;
			mismatches <= bad_count;
			pending <= expected_q.size();
			occupied <= seat_map;
		end
	end

endmodule

@@ bench/max_distance_slot_allocator_tb.sv @@
`timescale 1ns / 100ps

module max_distance_slot_allocator_tb;
	import msa_pkg::*;

	localparam logic OP_RELEASE = ~OP_TAKE;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // opcode, slot_index
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // chosen_slot, status
	int                   mismatches;
	int                   pending;
	logic [MAX_SLOTS-1:0] occupied;

	bit quiet;
	int row_n;
	int rx_hold;
	bit long_hold_done;
	int results_seen;

	max_distance_slot_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	msa_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mismatches(mismatches),
		.pending   (pending),
		.occupied  (occupied)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#(12 * 2000000);
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stall bursts plus one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
			long_hold_done <= 1'b0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready)
				results_seen <= results_seen + 1;
			if (quiet) begin
				m_tready <= 1'b1;
				rx_hold <= 0;
			end else if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else if (!long_hold_done && results_seen >= 60) begin
				m_tready <= 1'b0;
				rx_hold <= 400;
				long_hold_done <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				rx_hold <= $urandom_range(0, 8);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_req(input logic op, input logic [SLOT_W-1:0] idx);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {1'b0, idx, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] cnt);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_wdata <= cnt;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		row_n = (cnt == 0) ? 1 : (cnt > MAX_SLOTS) ? MAX_SLOTS : int'(cnt);
	endtask

	// mostly frees a slot that is really held, sometimes a random one
	function automatic logic [SLOT_W-1:0] release_target();
		int held[$];
		for (int i = 0; i < row_n; i++)
			if (occupied[i])
				held.push_back(i);
		if (held.size() != 0 && $urandom_range(0, 99) < 85)
			return SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
		return SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_cnt[12];
		int take_pct;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		quiet = 1'b0;
		row_n = MAX_SLOTS;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: walls, midpoints, bad releases, full row, shortened row
		write_slot_count(7'd64);
		send_req(OP_TAKE, 6'd63);
		send_req(OP_TAKE, 6'd0);
		send_req(OP_TAKE, 6'd42);
		send_req(OP_RELEASE, 6'd63);
		send_req(OP_RELEASE, 6'd63);
		send_req(OP_RELEASE, 6'd0);
		send_req(OP_TAKE, 6'd21);
		send_req(OP_RELEASE, 6'd40);
		write_slot_count(7'd1);
		send_req(OP_TAKE, 6'd0);
		send_req(OP_RELEASE, 6'd31);
		send_req(OP_RELEASE, 6'd0);
		send_req(OP_TAKE, 6'd63);
		send_req(OP_TAKE, 6'd0);
		write_slot_count(7'd0);
		send_req(OP_RELEASE, 6'd0);
		send_req(OP_TAKE, 6'd0);
		write_slot_count(7'd127);
		send_req(OP_RELEASE, 6'd31);
		send_req(OP_TAKE, 6'd0);
		send_req(OP_RELEASE, 6'd5);
		write_slot_count(7'd2);
		send_req(OP_TAKE, 6'd0);
		send_req(OP_TAKE, 6'd0);
		send_req(OP_TAKE, 6'd0);

		phase_cnt = '{7'd64, 7'd1, 7'd3, 7'd0, 7'd127, 7'd2, 7'd65,
			7'($urandom_range(1, 64)), 7'($urandom_range(4, 20)), 7'd64,
			7'($urandom_range(0, 127)), 7'($urandom_range(1, 64))};
		foreach (phase_cnt[p]) begin
			write_slot_count(phase_cnt[p]);
			take_pct = (p == 9) ? 95 : $urandom_range(25, 85);
			quiet = (p == 11);
			repeat (70) begin
				if ($urandom_range(0, 99) < take_pct)
					send_req(OP_TAKE, SLOT_W'($urandom_range(0, MAX_SLOTS - 1)));
				else
					send_req(OP_RELEASE, release_target());
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ max_distance_slot_allocator.f @@
src/msa_pkg.sv
src/msa_core.sv
src/max_distance_slot_allocator.sv
bench/msa_checker.sv
bench/max_distance_slot_allocator_tb.sv
